FILE: hw/rtl/modbus_rtu_meter_responder_assert.svh
// assertion macros for the meter responder checker
`ifndef MODBUS_RTU_METER_RESPONDER_ASSERT_SVH
`define MODBUS_RTU_METER_RESPONDER_ASSERT_SVH
// implication checked on every clock outside reset
`define MRM_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// next-cycle implication checked outside reset
`define MRM_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

FILE: hw/rtl/mrm_pkg.sv
//------------------------------------------------------------------------------
// mrm_pkg
// shared types and constants of the meter responder
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mrm_pkg;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] READ_REGISTER = 16'h0384;
  localparam logic [7:0] REPLY_COUNT = 8'd36;
  localparam int REPLY_LEN = 41;
  localparam int NUM_SLOTS = 9;
  localparam int DEF_SLOT_W = 4;

  localparam logic [2:0] REG_ADDR = 3'd0;
  localparam logic [2:0] REG_FUNC = 3'd1;
  localparam logic [2:0] REG_VDIV = 3'd2;
  localparam logic [2:0] REG_CDIV = 3'd3;
  localparam logic [2:0] REG_PMUL = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_WORD,
    ST_DIV,
    ST_MUL,
    ST_SEND
  } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/modbus_rtu_meter_responder.sv
//------------------------------------------------------------------------------
// modbus_rtu_meter_responder
// modbus rtu slave with nine stored meter readings and a 41-byte read reply
//------------------------------------------------------------------------------
// request byte: crc of lagging byte steps bit by bit, ready returns after that
// frame end with good request: per word a shift-subtract divide or a
//   shift-add multiply, then 4 bytes out with a crc pass each;
//   a full reply is also held up by output stalls
// sync reset restores registers, readings and receive state; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_meter_responder
  import mrm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  kind,
  input  wire logic [7:0]            rx_byte,
  input  wire logic                  frame_end,
  input  wire logic [DEF_SLOT_W-1:0] meas_slot,
  input  wire logic [23:0]           meas_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 tx_byte,
  output logic                       tx_last,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [23:0]           cfg_data
);
  // configuration
  logic [7:0]  slave_address, reply_function_code;
  logic [23:0] voltage_divisor, current_divisor;
  logic [15:0] power_multiplier;
  // receive state
  logic [23:0] readings [NUM_SLOTS];
  logic [7:0]  byte_count, first_byte;
  logic [15:0] running_crc, held_tail, register_field;
  // shared crc unit: one bit per cycle
  logic [15:0] crc;          // crc register being worked on
  logic [15:0] crc_shift;    // crc after one more bit step
  logic [2:0]  bit_cnt;
  logic        crc_rx;       // crc pass belongs to receive side
  logic        end_pend;     // frame end seen on this byte
  // reply sequencer
  state_t      state, state_next;
  logic [5:0]  pos;          // reply byte index
  logic [3:0]  slot;         // reading index of current word
  logic [31:0] word, acc;
  logic [23:0] rem;
  logic [5:0]  it;
  logic [15:0] reply_crc;
  logic [23:0] dvsr;
  logic [24:0] trial;

  logic in_acc, out_acc, good;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign trial = {rem, acc[31]} - {1'b0, dvsr};
  assign crc_shift = crc[0] ? (crc >> 1) ^ CRC_POLY : crc >> 1;

  // checked on the last crc cycle, so the lagging byte's final step is included
  assign good = (byte_count >= 8'd4) && (first_byte == slave_address) &&
                (crc_shift == {held_tail[7:0], held_tail[15:8]}) &&
                (register_field == READ_REGISTER);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc && !kind) state_next = ST_CRC;
      ST_CRC: begin
        if (bit_cnt == 3'd7) begin
          if (crc_rx) state_next = (end_pend && good) ? ST_SEND : ST_IDLE;
          else if (pos == 6'd39) state_next = ST_SEND;
          else if (pos >= 6'd3 && pos[1:0] == 2'b11) state_next = ST_WORD;
          else state_next = ST_SEND;
        end
      end
      ST_WORD: state_next = (slot == 4'd2 || slot == 4'd5 || slot == 4'd8) ?
                            ST_MUL : ST_DIV;
      ST_DIV:  if (it == 6'd31) state_next = ST_SEND;
      ST_MUL:  if (it == 6'd15) state_next = ST_SEND;
      // both crc bytes go out back to back
      ST_SEND: if (out_acc) state_next = (pos == 6'd40) ? ST_IDLE :
                                         (pos == 6'd39) ? ST_SEND : ST_CRC;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_SEND);
    tx_last   = (pos == 6'd40);
    case (pos)
      6'd0:  tx_byte = slave_address;
      6'd1:  tx_byte = reply_function_code;
      6'd2:  tx_byte = REPLY_COUNT;
      6'd39: tx_byte = reply_crc[7:0];
      6'd40: tx_byte = reply_crc[15:8];
      default: tx_byte = word[31:24];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slave_address <= 8'd1;
      reply_function_code <= 8'd3;
      voltage_divisor <= 24'd1;
      current_divisor <= 24'd1;
      power_multiplier <= 16'd1;
      for (int i = 0; i < NUM_SLOTS; i++) readings[i] <= '0;
      byte_count <= '0; first_byte <= '0;
      running_crc <= CRC_INIT; held_tail <= '0; register_field <= '0;
      bit_cnt <= '0; crc_rx <= 1'b0; end_pend <= 1'b0;
      pos <= '0; slot <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_ADDR: slave_address <= cfg_data[7:0];
          REG_FUNC: reply_function_code <= cfg_data[7:0];
          REG_VDIV: voltage_divisor <= cfg_data;
          REG_CDIV: current_divisor <= cfg_data;
          REG_PMUL: power_multiplier <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: if (in_acc) begin
          if (kind) begin
            if (meas_slot < DEF_SLOT_W'(NUM_SLOTS))
              readings[meas_slot] <= meas_value;
          end else begin
            // lagging byte enters crc only from the third byte on
            crc <= (byte_count >= 8'd2) ? running_crc ^ {8'h00, held_tail[15:8]}
                                        : running_crc;
            held_tail <= {held_tail[7:0], rx_byte};
            if (byte_count == 8'd0) first_byte <= rx_byte;
            if (byte_count == 8'd2) register_field[15:8] <= rx_byte;
            if (byte_count == 8'd3) register_field[7:0] <= rx_byte;
            if (byte_count != 8'd255) byte_count <= byte_count + 8'd1;
            crc_rx <= 1'b1; end_pend <= frame_end; bit_cnt <= '0;
          end
        end
        ST_CRC: begin
          if (byte_count < 8'd3 && crc_rx) crc <= crc;  // no shift on early bytes
          else crc <= crc_shift;
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            if (crc_rx) begin
              if (end_pend) begin
                byte_count <= '0; first_byte <= '0; held_tail <= '0;
                register_field <= '0; running_crc <= CRC_INIT;
                crc_rx <= 1'b0; pos <= '0; slot <= '0;
                reply_crc <= CRC_INIT;
              end else if (byte_count >= 8'd3) begin
                running_crc <= crc_shift;
              end
            end else begin
              reply_crc <= crc_shift;
            end
          end
        end
        ST_WORD: begin
          it <= '0; rem <= '0;
          if (slot == 4'd0 || slot == 4'd3 || slot == 4'd6) dvsr <= voltage_divisor;
          else dvsr <= current_divisor;
          if (slot == 4'd2 || slot == 4'd5 || slot == 4'd8)
            acc <= {16'h0000, readings[slot][15:0]};
          else acc <= {8'h00, readings[slot]};
        end
        ST_DIV: begin
          // restoring divide, one quotient bit a cycle; zero divisor gives all ones
          if (!trial[24]) begin
            rem <= trial[23:0];
            acc <= {acc[30:0], 1'b1};
          end else begin
            rem <= {rem[22:0], acc[31]};
            acc <= {acc[30:0], 1'b0};
          end
          it <= it + 6'd1;
          if (it == 6'd31) begin
            word <= {acc[30:0], ~trial[24]};
            slot <= slot + 4'd1;
          end
        end
        ST_MUL: begin
          // shift-add over multiplier bits, lsb first
          word <= (it == 6'd0 ? 32'd0 : word) +
                  (power_multiplier[it[3:0]] ? (acc << it[3:0]) : 32'd0);
          it <= it + 6'd1;
          if (it == 6'd15) slot <= slot + 4'd1;
        end
        ST_SEND: if (out_acc) begin
          if (pos >= 6'd3 && pos <= 6'd38) word <= {word[23:0], 8'h00};
          if (pos != 6'd40) begin
            crc <= reply_crc ^ {8'h00, tx_byte};
            bit_cnt <= '0;
            pos <= pos + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/mrm_checker.sv
//------------------------------------------------------------------------------
// mrm_checker
// port-level checks of the meter responder
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_meter_responder_assert.svh"
module mrm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic tx_last
);
  // no new word taken while a reply is going out
  `MRM_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready, "input ready during reply")
  // a reply never starts right after a word is taken
  `MRM_ASSERT_NEXT(a_crc_gap, clk, rst, in_valid && in_ready, !out_valid, "reply too early")
  // after the last word the block goes back to idle
  `MRM_ASSERT_NEXT(a_last_idle, clk, rst, out_valid && out_ready && tx_last, !out_valid,
    "reply continues past last")
endmodule
bind modbus_rtu_meter_responder mrm_checker u_mrm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .tx_last(tx_last)
);
`default_nettype wire

FILE: verif/tb_modbus_rtu_meter_responder.sv
//------------------------------------------------------------------------------
// tb_modbus_rtu_meter_responder
// drives request words and meter updates with random gaps and stalls, predicts
// each 41-word read reply and compares every tx word against that prediction
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_modbus_rtu_meter_responder;
  import mrm_pkg::*;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_MEAS = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        frame_end = 1'b0;
  logic [3:0]  meas_slot = '0;
  logic [23:0] meas_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  modbus_rtu_meter_responder u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .rx_byte(rx_byte), .frame_end(frame_end),
    .meas_slot(meas_slot), .meas_value(meas_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .tx_byte(tx_byte), .tx_last(tx_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of configuration and meter state
  logic [7:0]  own_addr;
  logic [7:0]  func_code;
  logic [23:0] vdiv, cdiv;
  logic [15:0] pmul;
  logic [23:0] meter [NUM_SLOTS];
  logic [7:0]  rx_count;
  logic [15:0] rx_crc, rx_tail, rx_reg;
  logic [7:0]  rx_first;

  // expected reply words: {tx_last, tx_byte}
  logic [8:0]  reply_q [$];
  int          mismatches = 0;
  logic        hold_off = 1'b0;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic logic [31:0] scaled_div(logic [23:0] n, logic [23:0] d);
    if (d == 0) return 32'hFFFF_FFFF;
    return {8'h00, n} / {8'h00, d};
  endfunction

  task automatic queue_reply();
    logic [7:0]  buff [REPLY_LEN];
    logic [31:0] w;
    logic [15:0] c;
    int p;
    p = 3;
    c = CRC_INIT;
    buff[0] = own_addr; buff[1] = func_code; buff[2] = REPLY_COUNT;
    for (int ph = 0; ph < 3; ph++) begin
      for (int q = 0; q < 3; q++) begin
        case (q)
          0: w = scaled_div(meter[ph*3], vdiv);
          1: w = scaled_div(meter[ph*3+1], cdiv);
          default: w = {16'h0, meter[ph*3+2][15:0]} * {16'h0, pmul};
        endcase
        for (int k = 3; k >= 0; k--) begin
          buff[p] = w[k*8 +: 8];
          p++;
        end
      end
    end
    for (int i = 0; i < 39; i++) c = crc_step(c, buff[i]);
    buff[39] = c[7:0]; buff[40] = c[15:8];
    for (int i = 0; i < REPLY_LEN; i++) reply_q.push_back({i == REPLY_LEN - 1, buff[i]});
  endtask

  task automatic clear_rx();
    rx_count = 0; rx_crc = CRC_INIT; rx_tail = 0; rx_first = 0; rx_reg = 0;
  endtask

  // apply one accepted word to the predictor
  task automatic predict_word(logic k, logic [7:0] b, logic e, logic [3:0] s,
                              logic [23:0] v);
    logic ok;
    if (k == KIND_MEAS) begin
      if (s < NUM_SLOTS) meter[s] = v;
    end else begin
      if (rx_count >= 2) rx_crc = crc_step(rx_crc, rx_tail[15:8]);
      rx_tail = {rx_tail[7:0], b};
      if (rx_count == 0) rx_first = b;
      else if (rx_count == 2) rx_reg[15:8] = b;
      else if (rx_count == 3) rx_reg[7:0] = b;
      if (rx_count != 8'd255) rx_count++;
      if (e) begin
        ok = rx_count >= 4 && rx_first == own_addr &&
             rx_crc == {rx_tail[7:0], rx_tail[15:8]} && rx_reg == READ_REGISTER;
        clear_rx();
        if (ok) queue_reply();
      end
    end
  endtask

  // valid stays up after an accept until the next word, a register write or an idle point drops it
  task automatic send_word(logic k, logic [7:0] b, logic e, logic [3:0] s,
                           logic [23:0] v);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind <= k; rx_byte <= b; frame_end <= e; meas_slot <= s; meas_value <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(k, b, e, s, v);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    in_valid <= 1'b0;
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ADDR: own_addr = val[7:0];
      REG_FUNC: func_code = val[7:0];
      REG_VDIV: vdiv = val;
      REG_CDIV: cdiv = val;
      default:  pmul = val[15:0];
    endcase
  endtask

  // idle point: all replies out plus margin for a frame still being crunched
  task automatic drain();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
    repeat (1000) @(negedge clk);
  endtask

  // full request frame {addr, func, 03, 84, cnt hi, cnt lo, crc lo, crc hi}
  task automatic send_request(logic [7:0] addr, logic [7:0] fn, bit corrupt,
                              bit bad_reg);
    logic [7:0]  f [8];
    logic [15:0] c;
    c = CRC_INIT;
    f[0] = addr; f[1] = fn;
    f[2] = bad_reg ? 8'h04 : READ_REGISTER[15:8];
    f[3] = READ_REGISTER[7:0];
    f[4] = 8'h00; f[5] = 8'h12;
    for (int i = 0; i < 6; i++) c = crc_step(c, f[i]);
    f[6] = c[7:0]; f[7] = c[15:8];
    if (corrupt) f[6] = f[6] ^ 8'h01;
    for (int i = 0; i < 8; i++) send_word(KIND_BYTE, f[i], i == 7, 4'($urandom), 24'($urandom));
  endtask

  task automatic random_meas();
    logic [3:0] s;
    s = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    send_word(KIND_MEAS, 8'($urandom), 1'($urandom), s, 24'($urandom));
  endtask

  // directed table: {kind, byte, end, slot, value}
  typedef struct packed {
    logic        k;
    logic [7:0]  b;
    logic        e;
    logic [3:0]  s;
    logic [23:0] v;
  } row_t;
  row_t dir_rows [] = '{
    '{KIND_MEAS, 8'hFF, 1'b1, 4'd0, 24'hFFFFFF},
    '{KIND_MEAS, 8'h00, 1'b0, 4'd1, 24'h000001},
    '{KIND_MEAS, 8'h00, 1'b0, 4'd2, 24'hFFFFFF},
    '{KIND_MEAS, 8'h00, 1'b0, 4'd8, 24'hABCDEF},
    '{KIND_MEAS, 8'h00, 1'b0, 4'd9, 24'h123456},   // slot out of range
    '{KIND_MEAS, 8'h00, 1'b0, 4'd15, 24'h654321},
    '{KIND_BYTE, 8'h01, 1'b0, 4'hF, 24'hFFFFFF},   // short frame
    '{KIND_BYTE, 8'h03, 1'b1, 4'h0, 24'h0},
    '{KIND_BYTE, 8'hFF, 1'b1, 4'h0, 24'h0},        // single byte frame
    '{KIND_BYTE, 8'h00, 1'b0, 4'h0, 24'h0},
    '{KIND_BYTE, 8'h03, 1'b0, 4'h0, 24'h0},
    '{KIND_BYTE, 8'h84, 1'b1, 4'h0, 24'h0}
  };

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else begin
        stall = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) stall = 0;
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  // long output hold-off counted in its own process
  initial begin
    wait (rst == 1'b0);
    repeat (3000) @(negedge clk);
    hold_off = 1'b1;
    repeat (6000) @(negedge clk);
    hold_off = 1'b0;
  end

  // reply checker
  always @(posedge clk) begin
    logic [8:0] exp_w;
    if (!rst && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h last %b", tx_byte, tx_last);
      end else begin
        exp_w = reply_q.pop_front();
        if (exp_w[7:0] !== tx_byte || exp_w[8] !== tx_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%b got %h/%b", exp_w[7:0], exp_w[8], tx_byte, tx_last);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("tb_modbus_rtu_meter_responder: done, errors");
    $finish;
  end

  initial begin
    int r;
    own_addr = 8'd1; func_code = 8'd3; vdiv = 24'd1; cdiv = 24'd1; pmul = 16'd1;
    for (int i = 0; i < NUM_SLOTS; i++) meter[i] = '0;
    clear_rx();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: all-zero readings, reset registers
    send_request(8'd1, 8'd3, 0, 0);
    foreach (dir_rows[i])
      send_word(dir_rows[i].k, dir_rows[i].b, dir_rows[i].e, dir_rows[i].s, dir_rows[i].v);
    send_request(8'd1, 8'd3, 1, 0);   // bad crc
    send_request(8'd1, 8'd3, 0, 1);   // wrong register
    send_request(8'd2, 8'd3, 0, 0);   // wrong address
    send_request(8'd1, 8'd3, 0, 0);
    // long frame saturating the byte count
    for (int i = 0; i < 260; i++) send_word(KIND_BYTE, 8'($urandom), i == 259, 4'd0, 24'd0);
    drain();

    // register extremes, zero divisor and multiplier
    write_reg(REG_ADDR, 24'd255); write_reg(REG_FUNC, 24'd0);
    write_reg(REG_VDIV, 24'd0); write_reg(REG_CDIV, 24'hFFFFFF);
    write_reg(REG_PMUL, 24'd65535);
    send_request(8'd255, 8'd4, 0, 0);
    drain();
    write_reg(REG_ADDR, 24'd0); write_reg(REG_FUNC, 24'd255);
    write_reg(REG_VDIV, 24'hFFFFFF); write_reg(REG_CDIV, 24'd0);
    write_reg(REG_PMUL, 24'd0);
    send_request(8'd0, 8'd3, 0, 0);
    drain();

    // random phases with new settings between them
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_ADDR, 24'($urandom_range(0, 255)));
      write_reg(REG_FUNC, 24'($urandom_range(0, 255)));
      write_reg(REG_VDIV, 24'($urandom_range(0, 300)));
      write_reg(REG_CDIV, 24'($urandom_range(1, 24'hFFFFFF)));
      write_reg(REG_PMUL, 24'($urandom_range(0, 65535)));
      for (int it = 0; it < 5; it++) begin
        r = $urandom_range(0, 9);
        if (r < 5) send_request(($urandom_range(0, 4) == 0) ? 8'($urandom) : own_addr,
                                8'($urandom), $urandom_range(0, 7) == 0,
                                $urandom_range(0, 7) == 0);
        else if (r < 8) random_meas();
        else send_word(KIND_BYTE, 8'($urandom), 1'($urandom), 4'($urandom), 24'($urandom));
      end
      // sender pauses until every reply is out
      drain();
    end

    // wait for the last replies, with a bound
    r = 0;
    while (reply_q.size() != 0 && r < 200000) begin
      @(negedge clk);
      r++;
    end
    repeat (1000) @(negedge clk);
    if (mismatches == 0 && reply_q.size() == 0)
      $display("tb_modbus_rtu_meter_responder: done, clean");
    else
      $display("tb_modbus_rtu_meter_responder: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

FILE: modbus_rtu_meter_responder.f
+incdir+hw/rtl
hw/rtl/mrm_pkg.sv
hw/rtl/modbus_rtu_meter_responder.sv
hw/rtl/mrm_checker.sv
verif/tb_modbus_rtu_meter_responder.sv
